FILE: rtl/core/notification_endpoint_badge_or_assert.svh
// Assertion macros used by the checker of the notification endpoint.
`ifndef NOTIFICATION_ENDPOINT_BADGE_OR_ASSERT_SVH
`define NOTIFICATION_ENDPOINT_BADGE_OR_ASSERT_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define NEB_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("neb check failed: same-cycle implication");

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define NEB_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("neb check failed: next-cycle implication");

`endif

FILE: rtl/core/neb_pkg.sv
// ----------------------------------------------------------------------------
// neb_pkg
// Types, codes and helpers shared by the notification endpoint modules.
// ----------------------------------------------------------------------------
`default_nettype none

package neb_pkg;

    localparam int THREADS     = 16;
    localparam int BADGE_BITS  = 64;
    localparam int BADGE_W     = 64;
    localparam int TID_W       = 4;
    localparam int MAX_RESULTS = 16;
    localparam int CNT_W       = $clog2(MAX_RESULTS);

    localparam logic [THREADS-1:0] FLAG_ONE = THREADS'(1);

    typedef logic [2:0] t_mode;
    localparam t_mode MODE_SIGNAL     = 3'd0;
    localparam t_mode MODE_WAIT       = 3'd1;
    localparam t_mode MODE_CANCEL_ALL = 3'd2;
    localparam t_mode MODE_CANCEL_ONE = 3'd3;
    localparam t_mode MODE_BIND       = 3'd4;
    localparam t_mode MODE_UNBIND     = 3'd5;

    typedef logic [2:0] t_action;
    localparam t_action ACT_NONE     = 3'd0;
    localparam t_action ACT_WAKE     = 3'd1;
    localparam t_action ACT_BADGE    = 3'd2;
    localparam t_action ACT_POLLFAIL = 3'd3;
    localparam t_action ACT_BLOCKED  = 3'd4;
    localparam t_action ACT_RESTART  = 3'd5;
    localparam t_action ACT_INACTIVE = 3'd6;
    localparam t_action ACT_ERROR    = 3'd7;

    typedef enum logic [1:0] {
        EP_IDLE    = 2'd0,
        EP_WAITING = 2'd1,
        EP_ACTIVE  = 2'd2
    } t_ep_state;

    typedef struct packed {
        t_mode              mode;
        logic [BADGE_W-1:0] badge;
        logic [TID_W-1:0]   thread_id;
        logic               blocking;
        logic               bound_waiting;
    } t_in_item;

    typedef struct packed {
        t_action            action;
        logic [TID_W-1:0]   target_thread;
        logic [BADGE_W-1:0] badge_out;
        logic               direct_switch;
        logic [1:0]         end_state;
        logic               last;
    } t_out_item;

    // Work class of the latched item, as seen by the controller.
    typedef enum logic [1:0] {
        KIND_SIMPLE,
        KIND_UNLINK,
        KIND_ENQUEUE,
        KIND_WALK
    } t_kind;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_SIMPLE,
        OP_LINK_READ,
        OP_UNLINK,
        OP_ENQ_LINK,
        OP_ENQ_DONE,
        OP_WALK_START,
        OP_WALK_STEP
    } t_dp_op;

    typedef enum logic [2:0] {
        CS_IDLE,
        CS_EXEC,
        CS_UNLINK,
        CS_ENQ,
        CS_WALK
    } t_ctrl_state;

    typedef struct packed {
        logic   load;
        t_dp_op op;
    } t_dp_cmd;

    typedef struct packed {
        t_kind kind;
        logic  walk_cont;
        logic  out_free;
    } t_dp_status;

    function automatic logic [BADGE_W-1:0] badge_widen(input logic [BADGE_BITS-1:0] b);
        logic [BADGE_W-1:0] w;
        w = '0;
        w[BADGE_BITS-1:0] = b;
        return w;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/core/neb_ram.sv
// ----------------------------------------------------------------------------
// neb_ram
// Generic single-write, single-read RAM with registered, enabled read.
// ----------------------------------------------------------------------------
`default_nettype none

module neb_ram #(
    parameter int WIDTH = 4,
    parameter int DEPTH = 16,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

FILE: rtl/core/neb_ctrl.sv
// ----------------------------------------------------------------------------
// neb_ctrl
// Sequencer: takes one item, steps the datapath through its operations.
// ----------------------------------------------------------------------------
`default_nettype none

module neb_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  neb_pkg::t_dp_status i_status,
    output neb_pkg::t_dp_cmd   o_cmd,
    output logic               o_busy
);

    import neb_pkg::*;

    t_ctrl_state r_state;
    t_ctrl_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= CS_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd.load = 1'b0;
        o_cmd.op   = OP_NONE;
        o_busy     = (r_state != CS_IDLE);
        case (r_state)
            CS_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = CS_EXEC;
                end
            end
            CS_EXEC: begin
                case (i_status.kind)
                    KIND_UNLINK: begin
                        o_cmd.op = OP_LINK_READ;
                        n_state  = CS_UNLINK;
                    end
                    KIND_ENQUEUE: begin
                        o_cmd.op = OP_ENQ_LINK;
                        n_state  = CS_ENQ;
                    end
                    KIND_WALK: begin
                        o_cmd.op = OP_WALK_START;
                        n_state  = CS_WALK;
                    end
                    default: begin
                        if (i_status.out_free) begin
                            o_cmd.op = OP_SIMPLE;
                            n_state  = CS_IDLE;
                        end
                    end
                endcase
            end
            CS_UNLINK: begin
                if (i_status.out_free) begin
                    o_cmd.op = OP_UNLINK;
                    n_state  = CS_IDLE;
                end
            end
            CS_ENQ: begin
                if (i_status.out_free) begin
                    o_cmd.op = OP_ENQ_DONE;
                    n_state  = CS_IDLE;
                end
            end
            CS_WALK: begin
                if (i_status.out_free) begin
                    o_cmd.op = OP_WALK_STEP;
                    if (!i_status.walk_cont) begin
                        n_state = CS_IDLE;
                    end
                end
            end
            default: begin
                n_state = CS_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

FILE: rtl/core/neb_dp.sv
// ----------------------------------------------------------------------------
// neb_dp
// Endpoint state, wait queue links, and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module neb_dp (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  neb_pkg::t_dp_cmd    i_cmd,
    input  neb_pkg::t_in_item   i_in_data,
    output neb_pkg::t_dp_status o_status,
    output logic                o_out_valid,
    output neb_pkg::t_out_item  o_out_data,
    input  logic                i_out_stall
);

    import neb_pkg::*;

    t_in_item                r_item;
    t_ep_state               r_state,       n_state;
    logic [BADGE_BITS-1:0]   r_pending,     n_pending;
    logic                    r_bound_valid, n_bound_valid;
    logic [TID_W-1:0]        r_bound,       n_bound;
    logic [TID_W-1:0]        r_head,        n_head;
    logic [TID_W-1:0]        r_tail,        n_tail;
    logic [THREADS-1:0]      r_flags,       n_flags;
    logic [TID_W-1:0]        r_cur,         n_cur;
    logic [CNT_W-1:0]        r_count,       n_count;
    logic                    r_out_valid;
    t_out_item               r_out;

    logic                    emit;
    t_out_item               emit_data;

    logic                    next_we,  prev_we,  next_re,  prev_re;
    logic [TID_W-1:0]        next_waddr, next_wdata, prev_waddr, prev_wdata;
    logic [TID_W-1:0]        next_raddr, prev_raddr;
    logic [TID_W-1:0]        next_rdata, prev_rdata;

    logic [TID_W-1:0]        tid;
    logic                    tid_ok;
    logic                    tid_queued;
    logic                    queue_empty;
    logic [BADGE_BITS-1:0]   in_badge;
    logic [THREADS-1:0]      cur_cleared;
    logic                    walk_cont;
    logic                    link_first, link_lastq;
    t_kind                   kind;

    assign tid         = r_item.thread_id;
    assign tid_ok      = ({1'b0, tid} < (TID_W + 1)'(THREADS));
    assign tid_queued  = r_flags[tid];
    assign queue_empty = (r_flags == '0);
    assign in_badge    = r_item.badge[BADGE_BITS-1:0];
    assign cur_cleared = r_flags & ~(FLAG_ONE << r_cur);
    assign link_first  = (r_head == r_cur);
    assign link_lastq  = (r_tail == r_cur);
    assign walk_cont   = (r_count != CNT_W'(MAX_RESULTS - 1)) && (cur_cleared != '0)
                         && cur_cleared[next_rdata];

    // Classify the latched item.
    always_comb begin
        kind = KIND_SIMPLE;
        case (r_item.mode)
            MODE_SIGNAL: begin
                if (r_state == EP_WAITING && !queue_empty) begin
                    kind = KIND_UNLINK;
                end
            end
            MODE_WAIT: begin
                if (tid_ok && !tid_queued && r_state != EP_ACTIVE && r_item.blocking) begin
                    kind = KIND_ENQUEUE;
                end
            end
            MODE_CANCEL_ALL: begin
                if (r_state == EP_WAITING && !queue_empty && r_flags[r_head]) begin
                    kind = KIND_WALK;
                end
            end
            MODE_CANCEL_ONE: begin
                if (tid_ok && r_state == EP_WAITING && tid_queued) begin
                    kind = KIND_UNLINK;
                end
            end
            default: begin
                kind = KIND_SIMPLE;
            end
        endcase
    end

    assign o_status.kind      = kind;
    assign o_status.walk_cont = walk_cont;
    assign o_status.out_free  = !r_out_valid || !i_out_stall;

    always_comb begin
        n_state       = r_state;
        n_pending     = r_pending;
        n_bound_valid = r_bound_valid;
        n_bound       = r_bound;
        n_head        = r_head;
        n_tail        = r_tail;
        n_flags       = r_flags;
        n_cur         = r_cur;
        n_count       = r_count;
        next_we       = 1'b0;
        next_waddr    = r_cur;
        next_wdata    = r_cur;
        prev_we       = 1'b0;
        prev_waddr    = r_cur;
        prev_wdata    = r_cur;
        next_re       = 1'b0;
        next_raddr    = r_cur;
        prev_re       = 1'b0;
        prev_raddr    = r_cur;
        emit          = 1'b0;
        emit_data.action        = ACT_NONE;
        emit_data.target_thread = tid;
        emit_data.badge_out     = '0;
        emit_data.direct_switch = 1'b0;
        emit_data.last          = 1'b1;

        case (i_cmd.op)
            OP_SIMPLE: begin
                emit = 1'b1;
                case (r_item.mode)
                    MODE_SIGNAL: begin
                        if (r_state == EP_ACTIVE) begin
                            n_pending = r_pending | in_badge;
                        end else if (r_bound_valid && r_item.bound_waiting) begin
                            n_state                 = EP_IDLE;
                            emit_data.action        = ACT_WAKE;
                            emit_data.target_thread = r_bound;
                            emit_data.badge_out     = badge_widen(in_badge);
                            emit_data.direct_switch = 1'b1;
                        end else begin
                            n_state   = EP_ACTIVE;
                            n_pending = in_badge;
                        end
                    end
                    MODE_WAIT: begin
                        if (!tid_ok || tid_queued) begin
                            emit_data.action = ACT_ERROR;
                        end else if (r_state == EP_ACTIVE) begin
                            n_state             = EP_IDLE;
                            emit_data.action    = ACT_BADGE;
                            emit_data.badge_out = badge_widen(r_pending);
                        end else begin
                            emit_data.action = ACT_POLLFAIL;
                        end
                    end
                    MODE_CANCEL_ALL: begin
                        // Waiting, head not queued: drop the queue, go idle.
                        if (r_state == EP_WAITING && !queue_empty) begin
                            n_flags = '0;
                            n_head  = '0;
                            n_tail  = '0;
                            n_state = EP_IDLE;
                        end
                    end
                    MODE_CANCEL_ONE: begin
                        emit_data.action = ACT_ERROR;
                    end
                    MODE_BIND: begin
                        if (!tid_ok) begin
                            emit_data.action = ACT_ERROR;
                        end else begin
                            n_bound_valid = 1'b1;
                            n_bound       = tid;
                        end
                    end
                    MODE_UNBIND: begin
                        if (r_bound_valid && r_bound == tid) begin
                            n_bound_valid = 1'b0;
                            n_bound       = '0;
                        end
                    end
                    default: begin
                        emit_data.action = ACT_ERROR;
                    end
                endcase
            end
            OP_LINK_READ: begin
                n_cur      = (r_item.mode == MODE_SIGNAL) ? r_head : tid;
                next_re    = 1'b1;
                next_raddr = n_cur;
                prev_re    = 1'b1;
                prev_raddr = n_cur;
            end
            OP_UNLINK: begin
                emit    = 1'b1;
                n_flags = cur_cleared;
                if (link_first && link_lastq) begin
                    n_head = '0;
                    n_tail = '0;
                end else if (link_first) begin
                    n_head     = next_rdata;
                    prev_we    = 1'b1;
                    prev_waddr = next_rdata;
                    prev_wdata = next_rdata;
                end else if (link_lastq) begin
                    n_tail     = prev_rdata;
                    next_we    = 1'b1;
                    next_waddr = prev_rdata;
                    next_wdata = prev_rdata;
                end else begin
                    next_we    = 1'b1;
                    next_waddr = prev_rdata;
                    next_wdata = next_rdata;
                    prev_we    = 1'b1;
                    prev_waddr = next_rdata;
                    prev_wdata = prev_rdata;
                end
                if (cur_cleared == '0) begin
                    n_state = EP_IDLE;
                end
                if (r_item.mode == MODE_SIGNAL) begin
                    emit_data.action        = ACT_WAKE;
                    emit_data.target_thread = r_cur;
                    emit_data.badge_out     = badge_widen(in_badge);
                end else begin
                    emit_data.action = ACT_INACTIVE;
                end
            end
            OP_ENQ_LINK: begin
                prev_we    = 1'b1;
                prev_waddr = tid;
                prev_wdata = queue_empty ? tid : r_tail;
                if (!queue_empty) begin
                    next_we    = 1'b1;
                    next_waddr = r_tail;
                    next_wdata = tid;
                end
            end
            OP_ENQ_DONE: begin
                emit       = 1'b1;
                next_we    = 1'b1;
                next_waddr = tid;
                next_wdata = tid;
                if (queue_empty) begin
                    n_head = tid;
                end
                n_tail           = tid;
                n_flags          = r_flags | (FLAG_ONE << tid);
                n_state          = EP_WAITING;
                emit_data.action = ACT_BLOCKED;
            end
            OP_WALK_START: begin
                n_cur      = r_head;
                n_count    = '0;
                next_re    = 1'b1;
                next_raddr = r_head;
            end
            OP_WALK_STEP: begin
                emit                    = 1'b1;
                emit_data.action        = ACT_RESTART;
                emit_data.target_thread = r_cur;
                emit_data.last          = !walk_cont;
                n_flags                 = cur_cleared;
                if (walk_cont) begin
                    n_cur      = next_rdata;
                    n_count    = r_count + CNT_W'(1);
                    next_re    = 1'b1;
                    next_raddr = next_rdata;
                end else begin
                    n_flags = '0;
                    n_head  = '0;
                    n_tail  = '0;
                    n_state = EP_IDLE;
                end
            end
            default: begin
                emit = 1'b0;
            end
        endcase
        // A walk always ends idle, so every restart beat carries idle.
        emit_data.end_state = (i_cmd.op == OP_WALK_STEP) ? EP_IDLE : n_state;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= EP_IDLE;
            r_pending     <= '0;
            r_bound_valid <= 1'b0;
            r_bound       <= '0;
            r_head        <= '0;
            r_tail        <= '0;
            r_flags       <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            r_state       <= n_state;
            r_pending     <= n_pending;
            r_bound_valid <= n_bound_valid;
            r_bound       <= n_bound;
            r_head        <= n_head;
            r_tail        <= n_tail;
            r_flags       <= n_flags;
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_item <= i_in_data;
        end
        if (emit) begin
            r_out <= emit_data;
        end
        r_cur   <= n_cur;
        r_count <= n_count;
    end

    neb_ram #(.WIDTH(TID_W), .DEPTH(THREADS)) u_next_ram (
        .i_clk   (i_clk),
        .i_we    (next_we),
        .i_waddr (next_waddr),
        .i_wdata (next_wdata),
        .i_re    (next_re),
        .i_raddr (next_raddr),
        .o_rdata (next_rdata)
    );

    neb_ram #(.WIDTH(TID_W), .DEPTH(THREADS)) u_prev_ram (
        .i_clk   (i_clk),
        .i_we    (prev_we),
        .i_waddr (prev_waddr),
        .i_wdata (prev_wdata),
        .i_re    (prev_re),
        .i_raddr (prev_raddr),
        .o_rdata (prev_rdata)
    );

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

`default_nettype wire

FILE: rtl/core/notification_endpoint_badge_or.sv
// ----------------------------------------------------------------------------
// notification_endpoint_badge_or
// Notification endpoint: badge OR-ing, FIFO of blocked waiters, bound thread.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_stall / i_in_data) carries one command
//   beat: signal, wait, cancel all, cancel one, bind or unbind. Output channel
//   (o_out_valid / i_out_stall / o_out_data) carries result beats; the final
//   beat of a command has last set. Every command gives at least one beat.
//   A beat moves on a rising edge with valid high and stall low.
//   Timing: one command at a time. After acceptance the block stalls its
//   input until the command is done. A plain command writes its result from
//   the exec state and frees the input on the same edge. Signal to a waiting
//   endpoint and cancel one read the links, then unlink: the queue links sit
//   in two small RAMs with a registered read port. Blocking wait links, then
//   enqueues (up to two writes to the next-link RAM). Cancel all walks the
//   queue, reading one next link per cycle while the output does not stall.
//   Output stall: the result register holds its beat; the sequencer waits
//   whenever it has a new beat and the register is full and stalled, so
//   a stalled receiver freezes the walk with no beat lost.
//   Reset (synchronous, active low): endpoint idle, no badge, no binding,
//   empty queue, no result pending. The link RAMs are not cleared; only
//   entries of queued threads are ever read.
// ----------------------------------------------------------------------------
`default_nettype none

module notification_endpoint_badge_or (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  neb_pkg::t_in_item  i_in_data,
    output logic               o_in_stall,
    output logic               o_out_valid,
    output neb_pkg::t_out_item o_out_data,
    input  logic               i_out_stall
);

    import neb_pkg::*;

    // Command from the sequencer, status back from the datapath.
    t_dp_cmd    dp_cmd;
    t_dp_status dp_status;
    logic       busy;

    // Sequencer: hold the input while a command is in flight, step the datapath.
    neb_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_status   (dp_status),
        .o_cmd      (dp_cmd),
        .o_busy     (busy)
    );

    // Datapath: endpoint state, link RAMs and the result register.
    neb_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (dp_cmd),
        .i_in_data   (i_in_data),
        .o_status    (dp_status),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data),
        .i_out_stall (i_out_stall)
    );

    // Stall follows the sequencer state only, never the input valid.
    assign o_in_stall = busy;

endmodule

`default_nettype wire

FILE: rtl/core/neb_checker.sv
// ----------------------------------------------------------------------------
// neb_checker
// Port-level checks on the notification endpoint, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "notification_endpoint_badge_or_assert.svh"

module neb_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input neb_pkg::t_in_item  i_in_data,
    input logic               o_in_stall,
    input logic               o_out_valid,
    input neb_pkg::t_out_item o_out_data,
    input logic               i_out_stall
);

    import neb_pkg::*;

    logic in_beat;
    logic nonlast_ok;
    logic badge_free;

    assign in_beat    = i_in_valid && !o_in_stall && (i_in_data.mode == i_in_data.mode);
    assign nonlast_ok = (o_out_data.action == ACT_RESTART) && (o_out_data.end_state == EP_IDLE);
    assign badge_free = (o_out_data.action != ACT_WAKE) && (o_out_data.action != ACT_BADGE);

    // A held beat stays put.
    `NEB_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall, o_out_valid && $stable(o_out_data))
    // One command at a time: input closes right after a beat is taken.
    `NEB_ASSERT_NEXT(a_one_cmd, i_clk, i_rst_n, in_beat, o_in_stall)
    // Only the cancel-all walk gives beats that are not the last.
    `NEB_ASSERT_IMPLY(a_nonlast, i_clk, i_rst_n, o_out_valid && !o_out_data.last, nonlast_ok)
    // Badge only travels with a wake or a badge delivery.
    `NEB_ASSERT_IMPLY(a_badge_zero, i_clk, i_rst_n, o_out_valid && badge_free, o_out_data.badge_out == '0)
    // Direct switch only on a wake.
    `NEB_ASSERT_IMPLY(a_dsw_wake, i_clk, i_rst_n, o_out_valid && o_out_data.direct_switch, o_out_data.action == ACT_WAKE)

endmodule

bind notification_endpoint_badge_or neb_checker u_neb_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .i_in_data   (i_in_data),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .o_out_data  (o_out_data),
    .i_out_stall (i_out_stall)
);

`default_nettype wire

FILE: tb/tb_notification_endpoint_badge_or.sv
// ----------------------------------------------------------------------------
// tb_notification_endpoint_badge_or
// Self-checking bench for the notification endpoint. A predictor mirrors the
// endpoint state, badge, binding and waiter queue. It turns every accepted
// command into the result beats the block must send, and a monitor checks
// each sent beat against them in order. Both channels see random gaps, and
// the receiver holds off once for a long stretch.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_notification_endpoint_badge_or;

    timeunit 1ns;
    timeprecision 1ps;

    import neb_pkg::*;

    // Mode codes the block does not define; both must come back as errors.
    localparam t_mode MODE_UNUSED6 = 3'd6;
    localparam t_mode MODE_UNUSED7 = 3'd7;

    localparam int RANDOM_ITEMS = 128;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 40;
    localparam int HOLD_CYCLES  = 150;

    // ------------------------------------------------------------------
    // Clock, reset and the block's ports
    // ------------------------------------------------------------------
    logic      clk       = 1'b0;
    logic      rst_n     = 1'b0;
    logic      in_valid  = 1'b0;
    t_in_item  in_data   = '0;
    logic      in_stall;
    logic      out_valid;
    t_out_item out_data;
    logic      out_stall = 1'b0;

    always #6 clk = ~clk;

    notification_endpoint_badge_or dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .i_in_data   (in_data),
        .o_in_stall  (in_stall),
        .o_out_valid (out_valid),
        .o_out_data  (out_data),
        .i_out_stall (out_stall)
    );

    // ------------------------------------------------------------------
    // Endpoint mirror: state after reset, updated on every accepted command
    // ------------------------------------------------------------------
    t_ep_state          ep_state   = EP_IDLE;
    logic [BADGE_W-1:0] pend_badge = '0;
    logic               bind_valid = 1'b0;
    logic [TID_W-1:0]   bind_tid   = '0;
    logic [TID_W-1:0]   q_head     = '0;
    logic [TID_W-1:0]   q_tail     = '0;
    logic [THREADS-1:0] waiters    = '0;
    logic [TID_W-1:0]   nxt [THREADS];
    logic [TID_W-1:0]   prv [THREADS];

    t_in_item  command_q [$];   // commands still to be offered
    t_out_item notify_results [$];   // beats owed by the block, oldest first

    int cmds_done    = 0;
    int beats_seen   = 0;
    int mism_cnt     = 0;
    int walks        = 0;
    int longest_walk = 0;
    int gen_cnt      = 0;
    int cycles       = 0;
    int hold_left    = 0;
    logic hold_done  = 1'b0;
    logic calm;

    // Quiet window: no gaps on either side while this stretch of commands runs.
    assign calm = (cmds_done >= 90) && (cmds_done < 130);

    // Append a waiter at the tail of the queue.
    task automatic enqueue_waiter(input logic [TID_W-1:0] t);
        if (waiters == '0) begin
            q_head = t;
            prv[t] = t;
        end else begin
            nxt[q_tail] = t;
            prv[t] = q_tail;
        end
        nxt[t] = t;
        q_tail = t;
        waiters[t] = 1'b1;
    endtask

    // Take a queued waiter out; the endpoint goes idle once nobody is left.
    task automatic unlink_waiter(input logic [TID_W-1:0] t);
        logic [TID_W-1:0] p;
        logic [TID_W-1:0] n;
        logic at_head;
        logic at_tail;
        p = prv[t];
        n = nxt[t];
        at_head = (q_head == t);
        at_tail = (q_tail == t);
        waiters[t] = 1'b0;
        if (at_head && at_tail) begin
            q_head = '0;
            q_tail = '0;
        end else if (at_head) begin
            q_head = n;
            prv[n] = n;
        end else if (at_tail) begin
            q_tail = p;
            nxt[p] = p;
        end else begin
            nxt[p] = n;
            prv[n] = p;
        end
        if (waiters == '0) ep_state = EP_IDLE;
    endtask

    // Advance the mirror by one command and queue the beats it must produce.
    task automatic endpoint_step(input t_in_item it);
        t_out_item        r;
        t_out_item        beats [$];
        logic [TID_W-1:0] t;
        logic [TID_W-1:0] nx;
        int               n;
        r = '{action: ACT_NONE, target_thread: it.thread_id, badge_out: '0,
              direct_switch: 1'b0, end_state: 2'd0, last: 1'b0};
        n = 0;
        case (it.mode)
            MODE_SIGNAL: begin
                // Queue head beats the bound thread; active ORs the badge in.
                if (ep_state == EP_WAITING && waiters != '0) begin
                    t = q_head;
                    unlink_waiter(t);
                    r.action = ACT_WAKE;
                    r.target_thread = t;
                    r.badge_out = it.badge;
                end else if (ep_state == EP_ACTIVE) begin
                    pend_badge = pend_badge | it.badge;
                end else if (bind_valid && it.bound_waiting) begin
                    ep_state = EP_IDLE;
                    r.action = ACT_WAKE;
                    r.target_thread = bind_tid;
                    r.badge_out = it.badge;
                    r.direct_switch = 1'b1;
                end else begin
                    ep_state = EP_ACTIVE;
                    pend_badge = it.badge;
                end
            end
            MODE_WAIT: begin
                if (waiters[it.thread_id]) begin
                    r.action = ACT_ERROR;
                end else if (ep_state == EP_ACTIVE) begin
                    // Hand over the badge; the register keeps its old value.
                    ep_state = EP_IDLE;
                    r.action = ACT_BADGE;
                    r.badge_out = pend_badge;
                end else if (it.blocking) begin
                    enqueue_waiter(it.thread_id);
                    ep_state = EP_WAITING;
                    r.action = ACT_BLOCKED;
                end else begin
                    r.action = ACT_POLLFAIL;
                end
            end
            MODE_CANCEL_ALL: begin
                if (ep_state == EP_WAITING && waiters != '0) begin
                    // Walk the queue from the head, one restart beat per waiter.
                    t = q_head;
                    while (n < MAX_RESULTS && waiters != '0 && waiters[t]) begin
                        nx = nxt[t];
                        waiters[t] = 1'b0;
                        r.action = ACT_RESTART;
                        r.target_thread = t;
                        beats.push_back(r);
                        n++;
                        t = nx;
                    end
                    walks++;
                    if (n > longest_walk) longest_walk = n;
                    waiters = '0;
                    q_head = '0;
                    q_tail = '0;
                    ep_state = EP_IDLE;
                end
            end
            MODE_CANCEL_ONE: begin
                if (ep_state != EP_WAITING || !waiters[it.thread_id]) begin
                    r.action = ACT_ERROR;
                end else begin
                    unlink_waiter(it.thread_id);
                    r.action = ACT_INACTIVE;
                end
            end
            MODE_BIND: begin
                bind_valid = 1'b1;
                bind_tid = it.thread_id;
            end
            MODE_UNBIND: begin
                if (bind_valid && bind_tid == it.thread_id) begin
                    bind_valid = 1'b0;
                    bind_tid = '0;
                end
            end
            default: begin
                r.action = ACT_ERROR;
            end
        endcase
        if (beats.size() == 0) beats.push_back(r);
        // End state is the state after the whole command, on every beat.
        foreach (beats[i]) begin
            beats[i].end_state = ep_state;
            beats[i].last = (i == beats.size() - 1);
            notify_results.push_back(beats[i]);
        end
    endtask

    // ------------------------------------------------------------------
    // Command building
    // ------------------------------------------------------------------
    function automatic t_in_item mk_item(input t_mode m, input logic [BADGE_W-1:0] b,
                                         input logic [TID_W-1:0] t, input logic blk,
                                         input logic bw);
        return '{mode: m, badge: b, thread_id: t, blocking: blk, bound_waiting: bw};
    endfunction

    // Mix full-width words with single bits and the two extremes.
    function automatic logic [BADGE_W-1:0] rand_badge();
        case ($urandom_range(0, 4))
            0: return 64'd1 << $urandom_range(0, 63);
            1: return '1;
            2: return '0;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    function automatic t_in_item rand_signal();
        return mk_item(MODE_SIGNAL, rand_badge(), 4'($urandom_range(0, 15)),
                       1'($urandom), 1'($urandom));
    endfunction

    task automatic push_gen(input t_in_item it);
        command_q.push_back(it);
        gen_cnt++;
    endtask

    // One episode: k distinct threads block, then a random mix of wakes,
    // cancels, polls, binding changes and noise, closed by a cancel-all or
    // by k signals, one for each thread that blocked first.
    task automatic add_episode(input int k);
        logic [TID_W-1:0] ids [THREADS];
        logic [TID_W-1:0] swap;
        int               j;
        int               m;
        for (int i = 0; i < THREADS; i++) ids[i] = TID_W'(i);
        for (int i = THREADS - 1; i > 0; i--) begin
            j = $urandom_range(0, i);
            swap = ids[i];
            ids[i] = ids[j];
            ids[j] = swap;
        end
        if ($urandom_range(0, 3) == 0)
            push_gen(mk_item(MODE_BIND, rand_badge(), ids[$urandom_range(0, 15)],
                             1'($urandom), 1'($urandom)));
        for (int i = 0; i < k; i++)
            push_gen(mk_item(MODE_WAIT, rand_badge(), ids[i], 1'b1, 1'($urandom)));
        m = $urandom_range(1, k + 3);
        repeat (m) begin
            case ($urandom_range(0, 9))
                0, 1, 2: push_gen(mk_item(MODE_CANCEL_ONE, rand_badge(),
                                          ids[$urandom_range(0, k - 1)],
                                          1'($urandom), 1'($urandom)));
                3, 4:    push_gen(rand_signal());
                5:       push_gen(mk_item(MODE_WAIT, rand_badge(),
                                          4'($urandom_range(0, 15)), 1'b0, 1'($urandom)));
                6:       push_gen(mk_item(MODE_WAIT, rand_badge(),
                                          ids[$urandom_range(0, 15)], 1'b1, 1'($urandom)));
                7:       push_gen(mk_item($urandom_range(0, 1) ? MODE_BIND : MODE_UNBIND,
                                          rand_badge(), 4'($urandom_range(0, 15)),
                                          1'($urandom), 1'($urandom)));
                default: push_gen(mk_item(3'($urandom_range(0, 7)), rand_badge(),
                                          4'($urandom_range(0, 15)),
                                          1'($urandom), 1'($urandom)));
            endcase
        end
        if ($urandom_range(0, 1) == 0) begin
            push_gen(mk_item(MODE_CANCEL_ALL, rand_badge(), 4'($urandom_range(0, 15)),
                             1'($urandom), 1'($urandom)));
        end else begin
            repeat (k) push_gen(rand_signal());
        end
        // Exercise idle and active: OR a few badges, then collect them.
        repeat ($urandom_range(0, 3)) push_gen(rand_signal());
        push_gen(mk_item(MODE_WAIT, rand_badge(), 4'($urandom_range(0, 15)),
                         1'($urandom), 1'($urandom)));
    endtask

    // ------------------------------------------------------------------
    // Input driver: hold a beat until accepted, gap at random otherwise
    // ------------------------------------------------------------------
    always @(posedge clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && !in_stall) begin
                endpoint_step(in_data);
                cmds_done <= cmds_done + 1;
            end
            if (!in_valid || !in_stall) begin
                if (command_q.size() != 0 && (calm || $urandom_range(0, 99) >= 32)) begin
                    in_data  <= command_q.pop_front();
                    in_valid <= 1'b1;
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Output stall: random, plus one long hold-off so the block backs up
    // ------------------------------------------------------------------
    always @(posedge clk) begin
        if (!rst_n) begin
            out_stall <= 1'b0;
        end else if (!hold_done && cmds_done >= 40) begin
            hold_done <= 1'b1;
            hold_left <= HOLD_CYCLES;
            out_stall <= 1'b1;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            out_stall <= 1'b1;
        end else begin
            out_stall <= !calm && ($urandom_range(0, 99) < 32);
        end
    end

    // ------------------------------------------------------------------
    // Monitor: compare each accepted result beat with the oldest owed one
    // ------------------------------------------------------------------
    always @(posedge clk) begin
        if (rst_n && out_valid && !out_stall) begin
            beats_seen <= beats_seen + 1;
            if (notify_results.size() == 0) begin
                if (mism_cnt < 10)
                    $display("unexpected beat: act=%0d tid=%0d badge=%h dsw=%b st=%0d last=%b",
                             out_data.action, out_data.target_thread, out_data.badge_out,
                             out_data.direct_switch, out_data.end_state, out_data.last);
                mism_cnt <= mism_cnt + 1;
            end else begin
                t_out_item want;
                want = notify_results.pop_front();
                if (out_data.action != want.action ||
                    out_data.target_thread != want.target_thread ||
                    out_data.badge_out != want.badge_out ||
                    out_data.direct_switch != want.direct_switch ||
                    out_data.end_state != want.end_state ||
                    out_data.last != want.last) begin
                    if (mism_cnt < 10) begin
                        $display("beat %0d mismatch", beats_seen);
                        $display("  exp act=%0d tid=%0d badge=%h dsw=%b st=%0d last=%b",
                                 want.action, want.target_thread, want.badge_out,
                                 want.direct_switch, want.end_state, want.last);
                        $display("  got act=%0d tid=%0d badge=%h dsw=%b st=%0d last=%b",
                                 out_data.action, out_data.target_thread, out_data.badge_out,
                                 out_data.direct_switch, out_data.end_state, out_data.last);
                    end
                    mism_cnt <= mism_cnt + 1;
                end
            end
        end
    end

    // Stop a hung run.
    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d beats still owed",
                     cycles, notify_results.size());
            $display("tb_notification_endpoint_badge_or failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus and end of run
    // ------------------------------------------------------------------
    initial begin
        // Directed: empty-endpoint corners, unknown modes, badge OR-ing,
        // bound-thread wake, queue order, duplicate wait, tail cancel.
        command_q.push_back(mk_item(MODE_UNBIND, '0, 4'd0, 1'b0, 1'b0));
        command_q.push_back(mk_item(MODE_CANCEL_ALL, '0, 4'd15, 1'b1, 1'b1));
        command_q.push_back(mk_item(MODE_CANCEL_ONE, '1, 4'd4, 1'b0, 1'b0));
        command_q.push_back(mk_item(MODE_UNUSED6, '1, 4'd15, 1'b1, 1'b1));
        command_q.push_back(mk_item(MODE_UNUSED7, '0, 4'd0, 1'b0, 1'b0));
        command_q.push_back(mk_item(MODE_SIGNAL, 64'h8000_0000_0000_0001, 4'd1, 1'b0, 1'b0));
        command_q.push_back(mk_item(MODE_SIGNAL, '0, 4'd2, 1'b0, 1'b1));
        command_q.push_back(mk_item(MODE_SIGNAL, 64'h5555_5555_5555_5555, 4'd3, 1'b1, 1'b0));
        command_q.push_back(mk_item(MODE_WAIT, '0, 4'd6, 1'b0, 1'b0));
        command_q.push_back(mk_item(MODE_WAIT, '0, 4'd6, 1'b0, 1'b0));
        command_q.push_back(mk_item(MODE_BIND, '0, 4'd15, 1'b0, 1'b0));
        command_q.push_back(mk_item(MODE_SIGNAL, '1, 4'd0, 1'b0, 1'b1));
        command_q.push_back(mk_item(MODE_BIND, '0, 4'd3, 1'b0, 1'b0));
        command_q.push_back(mk_item(MODE_UNBIND, '0, 4'd15, 1'b0, 1'b0));
        command_q.push_back(mk_item(MODE_WAIT, '0, 4'd5, 1'b1, 1'b0));
        command_q.push_back(mk_item(MODE_WAIT, '0, 4'd9, 1'b1, 1'b0));
        command_q.push_back(mk_item(MODE_WAIT, '0, 4'd2, 1'b1, 1'b0));
        command_q.push_back(mk_item(MODE_WAIT, '0, 4'd9, 1'b1, 1'b0));
        command_q.push_back(mk_item(MODE_WAIT, '0, 4'd7, 1'b0, 1'b0));
        command_q.push_back(mk_item(MODE_SIGNAL, 64'hA5A5_0000_FFFF_1234, 4'd0, 1'b0, 1'b1));
        command_q.push_back(mk_item(MODE_CANCEL_ONE, '0, 4'd2, 1'b0, 1'b0));
        command_q.push_back(mk_item(MODE_CANCEL_ONE, '0, 4'd2, 1'b0, 1'b0));
        command_q.push_back(mk_item(MODE_CANCEL_ALL, '0, 4'd0, 1'b0, 1'b0));
        command_q.push_back(mk_item(MODE_UNBIND, '0, 4'd3, 1'b0, 1'b0));

        // Random: open with a full sixteen-waiter queue, then mostly small ones.
        add_episode(THREADS);
        while (gen_cnt < RANDOM_ITEMS) begin
            if ($urandom_range(0, 4) == 0) add_episode($urandom_range(7, THREADS));
            else add_episode($urandom_range(1, 6));
        end

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // Drain: every command offered and every owed beat received.
        @(posedge clk);
        while (command_q.size() != 0 || in_valid || notify_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("ran %0d commands, checked %0d result beats, %0d mismatches",
                 cmds_done, beats_seen, mism_cnt);
        $display("cancel-all walks: %0d, longest %0d waiters", walks, longest_walk);
        if (mism_cnt == 0) begin
            $display("tb_notification_endpoint_badge_or passed");
        end else begin
            $display("tb_notification_endpoint_badge_or failed");
        end
        $finish;
    end

endmodule

`default_nettype wire

FILE: notification_endpoint_badge_or.f
+incdir+rtl/core
rtl/core/neb_pkg.sv
rtl/core/neb_ram.sv
rtl/core/neb_ctrl.sv
rtl/core/neb_dp.sv
rtl/core/notification_endpoint_badge_or.sv
rtl/core/neb_checker.sv
tb/tb_notification_endpoint_badge_or.sv
